FILE: design/stepper_coil_to_step_output_assert.svh
// Assertion macros used by the stepper coil converter top level.
`ifndef STEPPER_COIL_TO_STEP_OUTPUT_ASSERT_SVH
`define STEPPER_COIL_TO_STEP_OUTPUT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define STC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked out of reset.
`define STC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define STC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define STC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/stc_pkg.sv
// Shared types, register codes and reset values of the stepper coil converter.
`default_nettype none
package stc_pkg;

    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 14;
    localparam int DEADBAND_W   = 10;
    localparam int LIMIT_W      = 14;
    localparam int THR_W        = 8;
    localparam int REF_START_W  = 10;
    localparam int TICK_W       = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_STEP_MODE    = 3'd0,
        REG_DEADBAND     = 3'd1,
        REG_ADJUST_LIMIT = 3'd2,
        REG_COUNT_MIN    = 3'd3,
        REG_COUNT_MAX    = 3'd4,
        REG_REF_START    = 3'd5
    } t_reg_index;

    typedef enum logic [1:0] {
        MODE_QUAD    = 2'd0,
        MODE_DIR     = 2'd1,
        MODE_AB      = 2'd2,
        MODE_SERIAL  = 2'd3
    } t_step_mode;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_FWD  = 2'd1,
        EV_REV  = 2'd2
    } t_event;

    localparam logic [DEADBAND_W-1:0]  DEADBAND_RESET  = 10'd20;
    localparam logic [LIMIT_W-1:0]     LIMIT_RESET     = 14'd1000;
    localparam logic [THR_W-1:0]       COUNT_MIN_RESET = 8'd2;
    localparam logic [THR_W-1:0]       COUNT_MAX_RESET = 8'd16;
    localparam logic [REF_START_W-1:0] REF_START_RESET = 10'd512;
    localparam logic [TICK_W-1:0]      TICK_SAT        = 8'd255;
    localparam int                     TICK_SHIFT      = 3;

    // Settings each channel lane needs.
    typedef struct packed {
        logic [DEADBAND_W-1:0] deadband;
        logic [LIMIT_W-1:0]    adjust_limit;
    } t_lane_cfg;

    // Settings the merge stage needs.
    typedef struct packed {
        t_step_mode       step_mode;
        logic [THR_W-1:0] count_min;
        logic [THR_W-1:0] count_max;
    } t_merge_cfg;

    // One result word.
    typedef struct packed {
        t_event serial_step;
        logic   pin_b;
        logic   pin_a;
    } t_result;

endpackage
`default_nettype wire

FILE: design/stc_lane.sv
// One coil channel: reference tracking and consecutive-high counting.
`default_nettype none
module stc_lane
    import stc_pkg::*;
#(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_adv,
    input  wire logic                   i_load,
    input  wire logic [REF_START_W-1:0] i_ref_start,
    input  wire t_lane_cfg              i_cfg,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    output logic      [COUNT_BITS-1:0]  o_count,
    output logic                        o_high
);

    localparam int XW    = (SAMPLE_BITS > REF_START_W) ? SAMPLE_BITS : REF_START_W;
    localparam int CW    = ((SAMPLE_BITS > DEADBAND_W) ? SAMPLE_BITS : DEADBAND_W) + 1;
    localparam int SUM_W = ((SAMPLE_BITS > LIMIT_W + 1) ? SAMPLE_BITS : LIMIT_W + 1) + 2;

    logic [SAMPLE_BITS-1:0]  r_ref,   n_ref;
    logic signed [SUM_W-1:0] r_sum,   n_sum;
    logic [COUNT_BITS-1:0]   r_count, n_count;

    logic signed [SUM_W-1:0] sum_add;
    logic signed [SUM_W-1:0] limit_s;
    logic [XW-1:0]           load_x;
    logic [XW-1:0]           reset_x;
    logic [CW-1:0]           high_lim;

    always_comb begin
        limit_s = $signed(SUM_W'(i_cfg.adjust_limit));
        sum_add = r_sum + $signed(SUM_W'(r_ref)) - $signed(SUM_W'(i_sample));
        n_ref   = r_ref;
        n_sum   = sum_add;
        if (sum_add < -limit_s) begin
            if (r_ref != '1) n_ref = r_ref + 1'b1;
            n_sum = '0;
        end else if (sum_add > limit_s) begin
            if (r_ref != '0) n_ref = r_ref - 1'b1;
            n_sum = '0;
        end

        // Count against the reference just updated.
        high_lim = CW'(n_ref) + CW'(i_cfg.deadband);
        o_high   = CW'(i_sample) > high_lim;
        n_count  = r_count;
        if (o_high) begin
            if (r_count != '1) n_count = r_count + 1'b1;
        end else if (i_sample < n_ref) begin
            n_count = '0;
        end
    end

    assign o_count = n_count;
    assign load_x  = XW'(i_ref_start);
    assign reset_x = XW'(REF_START_RESET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref   <= reset_x[SAMPLE_BITS-1:0];
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_load) begin
            // Reference restarts; the offset sum carries on.
            r_ref <= load_x[SAMPLE_BITS-1:0];
        end else if (i_adv) begin
            r_ref   <= n_ref;
            r_sum   <= n_sum;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

FILE: design/stc_merge.sv
// Merge stage: step detection, adaptive threshold and output line encoding.
`default_nettype none
module stc_merge
    import stc_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_adv,
    input  wire t_merge_cfg            i_cfg,
    input  wire logic [COUNT_BITS-1:0] i_count_a,
    input  wire logic [COUNT_BITS-1:0] i_count_b,
    input  wire logic                  i_high_a,
    input  wire logic                  i_high_b,
    output t_result                    o_result
);

    logic              r_stepping, n_stepping;
    logic [TICK_W-1:0] r_ticks,    n_ticks;
    logic [THR_W-1:0]  r_thr,      n_thr;
    logic              r_line_a,   n_line_a;
    logic              r_line_b,   n_line_b;

    logic              detect;
    logic              fwd;
    logic [TICK_W-1:0] ticks_mid;
    logic [THR_W-1:0]  shifted;
    t_event            event_w;

    always_comb begin
        n_line_a   = r_line_a;
        n_line_b   = r_line_b;
        n_stepping = r_stepping;
        ticks_mid  = r_ticks;
        n_thr      = r_thr;
        event_w    = EV_NONE;

        if (r_stepping && i_cfg.step_mode == MODE_DIR) n_line_a = 1'b1;

        // Both counts dropped: close the step.
        if (r_stepping && i_count_a == '0 && i_count_b == '0) begin
            if (i_cfg.step_mode == MODE_DIR || i_cfg.step_mode == MODE_AB) begin
                n_line_a = 1'b0;
                n_line_b = 1'b0;
            end
            n_stepping = 1'b0;
            ticks_mid  = '0;
        end

        detect = !n_stepping && i_high_a && i_high_b &&
                 i_count_a >= COUNT_BITS'(r_thr) && i_count_b >= COUNT_BITS'(r_thr);
        fwd     = i_count_a > i_count_b;
        shifted = THR_W'(ticks_mid >> TICK_SHIFT);

        if (detect) begin
            case (i_cfg.step_mode)
                MODE_QUAD: begin
                    if (fwd) begin
                        if (!n_line_a && !n_line_b)     n_line_a = 1'b1;
                        else if (n_line_a && !n_line_b) n_line_b = 1'b1;
                        else if (n_line_a && n_line_b)  n_line_a = 1'b0;
                        else                            n_line_b = 1'b0;
                    end else begin
                        if (!n_line_a && !n_line_b)     n_line_b = 1'b1;
                        else if (!n_line_a && n_line_b) n_line_a = 1'b1;
                        else if (n_line_a && n_line_b)  n_line_b = 1'b0;
                        else                            n_line_a = 1'b0;
                    end
                end
                MODE_DIR: n_line_b = fwd;
                MODE_AB: begin
                    if (fwd) n_line_a = 1'b1;
                    else     n_line_b = 1'b1;
                end
                default: event_w = fwd ? EV_FWD : EV_REV;
            endcase
            // Lower clamp wins below count_min even if limits cross.
            if (shifted < i_cfg.count_min)      n_thr = i_cfg.count_min;
            else if (shifted > i_cfg.count_max) n_thr = i_cfg.count_max;
            else                                n_thr = shifted;
            n_stepping = 1'b1;
        end

        n_ticks = (ticks_mid != TICK_SAT) ? ticks_mid + 1'b1 : ticks_mid;

        o_result.pin_a       = n_line_a;
        o_result.pin_b       = n_line_b;
        o_result.serial_step = event_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stepping <= 1'b0;
            r_ticks    <= '0;
            r_thr      <= COUNT_MAX_RESET;
            r_line_a   <= 1'b0;
            r_line_b   <= 1'b0;
        end else if (i_adv) begin
            r_stepping <= n_stepping;
            r_ticks    <= n_ticks;
            r_thr      <= n_thr;
            r_line_a   <= n_line_a;
            r_line_b   <= n_line_b;
        end
    end

endmodule
`default_nettype wire

FILE: design/stepper_coil_to_step_output.sv
// Top level of the stepper coil to step output converter.
//
//   channel   direction  handshake                       payload
//   s_axis    in         i_s_axis_tvalid/o_s_axis_tready   sample_a, sample_b
//   m_axis    out        o_m_axis_tvalid/i_m_axis_tready   pin_a, pin_b, serial_step
//   cfg       in         i_cfg_valid/o_cfg_ready          i_cfg_index, i_cfg_data
//
// One tick word is taken per cycle unless stalled; its result word is ready the cycle after.
// Both lanes and the merge stage are combinational around their per-tick state registers.
// Reset is synchronous: registers but r_out return to defaults, lines low, references at 512.
// A stalled result word holds; the input takes a new word only if the output frees.
// The configuration port is always ready.
`default_nettype none
`include "stepper_coil_to_step_output_assert.svh"
module stepper_coil_to_step_output
    import stc_pkg::*;
#(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 16,
    localparam int IN_W       = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_W-1:0]        i_s_axis_tdata,   // sample_a, sample_b, zero pad
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic      [7:0]             o_m_axis_tdata,   // pin_a, pin_b, serial_step[1:0], pad
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_step_mode             r_step_mode;
    logic [DEADBAND_W-1:0]  r_deadband;
    logic [LIMIT_W-1:0]     r_adjust_limit;
    logic [THR_W-1:0]       r_count_min;
    logic [THR_W-1:0]       r_count_max;

    logic                   r_out_valid;
    t_result                r_out;

    logic                   in_accept;
    logic                   cfg_wr;
    logic                   ref_load;
    t_lane_cfg              lane_cfg;
    t_merge_cfg             merge_cfg;
    logic [COUNT_BITS-1:0]  count_a, count_b;
    logic                   high_a, high_b;
    t_result                result;

    assign o_cfg_ready     = 1'b1;
    assign cfg_wr          = i_cfg_valid && o_cfg_ready;
    assign ref_load        = cfg_wr && i_cfg_index == REG_REF_START;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    assign lane_cfg.deadband      = r_deadband;
    assign lane_cfg.adjust_limit  = r_adjust_limit;
    assign merge_cfg.step_mode    = r_step_mode;
    assign merge_cfg.count_min    = r_count_min;
    assign merge_cfg.count_max    = r_count_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_mode    <= MODE_QUAD;
            r_deadband     <= DEADBAND_RESET;
            r_adjust_limit <= LIMIT_RESET;
            r_count_min    <= COUNT_MIN_RESET;
            r_count_max    <= COUNT_MAX_RESET;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                REG_STEP_MODE:    r_step_mode    <= t_step_mode'(i_cfg_data[1:0]);
                REG_DEADBAND:     r_deadband     <= i_cfg_data[DEADBAND_W-1:0];
                REG_ADJUST_LIMIT: r_adjust_limit <= i_cfg_data[LIMIT_W-1:0];
                REG_COUNT_MIN:    r_count_min    <= i_cfg_data[THR_W-1:0];
                REG_COUNT_MAX:    r_count_max    <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    stc_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_lane_a (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (in_accept),
        .i_load      (ref_load),
        .i_ref_start (i_cfg_data[REF_START_W-1:0]),
        .i_cfg       (lane_cfg),
        .i_sample    (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_count     (count_a),
        .o_high      (high_a)
    );

    stc_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_lane_b (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (in_accept),
        .i_load      (ref_load),
        .i_ref_start (i_cfg_data[REF_START_W-1:0]),
        .i_cfg       (lane_cfg),
        .i_sample    (i_s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .o_count     (count_b),
        .o_high      (high_b)
    );

    stc_merge #(
        .COUNT_BITS (COUNT_BITS)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (in_accept),
        .i_cfg     (merge_cfg),
        .i_count_a (count_a),
        .i_count_b (count_b),
        .i_high_a  (high_a),
        .i_high_b  (high_b),
        .o_result  (result)
    );

    // Output register: load on accept, drop when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) r_out <= result;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out.serial_step, r_out.pin_b, r_out.pin_a};

    `STC_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !i_m_axis_tready, !o_s_axis_tready)
    `STC_ASSERT_NXT(a_accept_gives_word, i_clk, i_rst_n, in_accept, r_out_valid)
    `STC_ASSERT_NXT(a_event_serial_only, i_clk, i_rst_n, in_accept, r_out.serial_step == EV_NONE || $past(r_step_mode) == MODE_SERIAL)

endmodule
`default_nettype wire
